// File: rtl/dhf_pkg.sv
// Shared constants and character helpers for the double to hex-float text block.
package dhf_pkg;

    localparam int VALUE_W = 64;
    localparam int EXP_W   = 11;
    localparam int FRAC_W  = 52;
    localparam int MAG_W   = 11;
    localparam int BCD_W   = 16;
    localparam int CHAR_W  = 8;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [EXP_W-1:0] EXP_BIAS     = 11'd1023;
    localparam logic [MAG_W-1:0] SUBN_BASE    = 11'd1022;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
    localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CASE_MASK = 8'hDF;
    localparam logic [CHAR_W-1:0] UPPER_A   = 8'h41;

    function automatic logic [CHAR_W-1:0] letter(logic [CHAR_W-1:0] c, logic up);
        return up ? (c & CASE_MASK) : c;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] nib, logic up);
        logic [CHAR_W-1:0] base;
        base = up ? UPPER_A : CH_A;
        if (nib < 4'd10) begin
            return CH_0 + {4'b0, nib};
        end
        return base + {4'b0, nib} - 8'd10;
    endfunction

endpackage

// File: rtl/dhf_if.sv
// Valid/ready channel interfaces for the input values and the output characters.
interface dhf_in_if;
    logic                         valid;
    logic                         ready;
    logic [dhf_pkg::VALUE_W-1:0]  value_bits;
    logic                         upper_case;

    modport source (output valid, output value_bits, output upper_case, input ready);
    modport sink   (input valid, input value_bits, input upper_case, output ready);
endinterface

interface dhf_out_if;
    logic                         valid;
    logic                         ready;
    logic [dhf_pkg::CHAR_W-1:0]   char_code;
    logic                         last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/double_to_hex_float_text_top.sv
// Top level: renders an IEEE-754 double as hex-float text, one character per transfer.
//
// One value is taken per transfer, and the block is busy until its last character has
// been handed to the output register. Infinity and NaN give 3 or 4 characters, zero
// 6 or 7, and these go from the transfer straight to the emitter. A normal number
// first passes through the bit-serial exponent to decimal converter (11 shifts plus
// start and handoff), then emits 8 to 24 characters at one per cycle while the output
// is not stalled. A subnormal number is first normalized by the one-bit shifter, one
// place per step, for a shift of s places (s from 1 to 52). Output stalls simply hold the emitter.
module double_to_hex_float_text_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dhf_in_if.sink    i_in,
    dhf_out_if.source o_out
);
    import dhf_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NORM = 3'd1;
    localparam logic [2:0] ST_CONV = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [3:0] PH_SIGN  = 4'd0;
    localparam logic [3:0] PH_W0    = 4'd1;
    localparam logic [3:0] PH_W1    = 4'd2;
    localparam logic [3:0] PH_W2    = 4'd3;
    localparam logic [3:0] PH_0     = 4'd4;
    localparam logic [3:0] PH_X     = 4'd5;
    localparam logic [3:0] PH_Z0    = 4'd6;
    localparam logic [3:0] PH_ONE   = 4'd7;
    localparam logic [3:0] PH_DOT   = 4'd8;
    localparam logic [3:0] PH_FRAC  = 4'd9;
    localparam logic [3:0] PH_P     = 4'd10;
    localparam logic [3:0] PH_ESIGN = 4'd11;
    localparam logic [3:0] PH_EDIG  = 4'd12;

    localparam int SHIFT_W = $clog2(FRAC_W + 1);

    logic [2:0]          r_state;
    logic [3:0]          r_ph, n_ph;
    logic                r_neg, r_up, r_special, r_nan, r_zero, r_eneg;
    logic [FRAC_W:0]     r_frac;
    logic [SHIFT_W-1:0]  r_shift;
    logic [MAG_W-1:0]    r_mag;
    logic [BCD_W-1:0]    r_bcd;
    logic [2:0]          r_ndig, n_ndig;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_char, ch;
    logic                r_last, last;

    logic                accept, emit, bcd_start, bcd_done;
    logic [BCD_W-1:0]    bcd_val;
    logic [EXP_W-1:0]    in_exp;
    logic [FRAC_W-1:0]   in_frac;

    assign in_exp  = i_in.value_bits[VALUE_W-2 -: EXP_W];
    assign in_frac = i_in.value_bits[FRAC_W-1:0];

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign emit       = (r_state == ST_EMIT) && (!r_out_valid || o_out.ready);
    assign bcd_start  = (r_state == ST_CONV);

    dhf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_bin   (r_mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd_val)
    );

    always_comb begin
        if (r_mag >= 11'd1000) begin
            n_ndig = 3'd4;
        end else if (r_mag >= 11'd100) begin
            n_ndig = 3'd3;
        end else if (r_mag >= 11'd10) begin
            n_ndig = 3'd2;
        end else begin
            n_ndig = 3'd1;
        end
    end

    always_comb begin
        ch   = CH_0;
        last = 1'b0;
        n_ph = r_ph;
        case (r_ph)
            PH_SIGN: begin
                ch   = CH_MINUS;
                n_ph = r_special ? PH_W0 : PH_0;
            end
            PH_W0: begin
                ch   = letter(r_nan ? CH_N : CH_I, r_up);
                n_ph = PH_W1;
            end
            PH_W1: begin
                ch   = letter(r_nan ? CH_A : CH_N, r_up);
                n_ph = PH_W2;
            end
            PH_W2: begin
                ch   = letter(r_nan ? CH_N : CH_F, r_up);
                last = 1'b1;
            end
            PH_0: begin
                ch   = CH_0;
                n_ph = PH_X;
            end
            PH_X: begin
                ch   = letter(CH_X, r_up);
                n_ph = r_zero ? PH_Z0 : PH_ONE;
            end
            PH_Z0: begin
                ch   = CH_0;
                n_ph = PH_P;
            end
            PH_ONE: begin
                ch   = CH_1;
                n_ph = PH_DOT;
            end
            PH_DOT: begin
                ch   = CH_DOT;
                n_ph = PH_FRAC;
            end
            PH_FRAC: begin
                if (r_frac[FRAC_W-1:0] == '0) begin
                    ch   = CH_0;
                    n_ph = PH_P;
                end else begin
                    ch   = hex_char(r_frac[FRAC_W-1 -: 4], r_up);
                    n_ph = (r_frac[FRAC_W-5:0] == '0) ? PH_P : PH_FRAC;
                end
            end
            PH_P: begin
                ch   = letter(CH_P, r_up);
                n_ph = PH_ESIGN;
            end
            PH_ESIGN: begin
                ch   = r_eneg ? CH_MINUS : CH_PLUS;
                n_ph = PH_EDIG;
            end
            PH_EDIG: begin
                ch   = hex_char(r_bcd[BCD_W-1 -: 4], 1'b0);
                last = (r_ndig == 3'd1);
            end
            default: begin
                ch   = CH_0;
                last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (in_exp == EXP_ALL_ONES || (in_exp == '0 && in_frac == '0)) begin
                            r_state <= ST_EMIT;
                        end else if (in_exp == '0) begin
                            r_state <= ST_NORM;
                        end else begin
                            r_state <= ST_CONV;
                        end
                    end
                end
                ST_NORM: begin
                    if (r_frac[FRAC_W]) begin
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (bcd_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit && last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= ch;
            r_last <= last;
            r_ph   <= n_ph;
            if (r_ph == PH_FRAC) begin
                r_frac <= {r_frac[FRAC_W-4:0], 4'b0};
            end
            if (r_ph == PH_EDIG) begin
                r_bcd  <= {r_bcd[BCD_W-5:0], 4'b0};
                r_ndig <= r_ndig - 1'b1;
            end
        end
        case (r_state)
            ST_IDLE: begin
                r_neg     <= i_in.value_bits[VALUE_W-1];
                r_up      <= i_in.upper_case;
                r_frac    <= {1'b0, in_frac};
                r_special <= (in_exp == EXP_ALL_ONES);
                r_nan     <= (in_frac != '0);
                r_zero    <= (in_exp == '0) && (in_frac == '0);
                r_shift   <= '0;
                r_bcd     <= '0;
                r_ndig    <= 3'd1;
                r_eneg    <= (in_exp < EXP_BIAS) && (in_exp != '0 || in_frac != '0);
                r_mag     <= (in_exp < EXP_BIAS) ? EXP_BIAS - in_exp : in_exp - EXP_BIAS;
                if (i_in.value_bits[VALUE_W-1]) begin
                    r_ph <= PH_SIGN;
                end else if (in_exp == EXP_ALL_ONES) begin
                    r_ph <= PH_W0;
                end else begin
                    r_ph <= PH_0;
                end
            end
            ST_NORM: begin
                if (r_frac[FRAC_W]) begin
                    r_mag <= SUBN_BASE + MAG_W'(r_shift);
                end else begin
                    r_frac  <= {r_frac[FRAC_W-1:0], 1'b0};
                    r_shift <= r_shift + 1'b1;
                end
            end
            ST_WAIT: begin
                r_ndig <= n_ndig;
                case (n_ndig)
                    3'd1:    r_bcd <= {bcd_val[3:0], 12'b0};
                    3'd2:    r_bcd <= {bcd_val[7:0], 8'b0};
                    3'd3:    r_bcd <= {bcd_val[11:0], 4'b0};
                    default: r_bcd <= bcd_val;
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM) |-> (r_frac != '0))
        else $error("normalization entered with a zero fraction");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NORM) |-> (r_shift <= SHIFT_W'(FRAC_W)))
        else $error("normalization shift out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> (r_state == ST_IDLE && o_out.last_char && o_out.valid))
        else $error("final character did not end the item");

    a_ndig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_ph == PH_EDIG) |-> (r_ndig != 3'd0 && r_ndig <= 3'd4))
        else $error("exponent digit count out of range");

endmodule

// File: rtl/dhf_bcd.sv
// Iterative binary to BCD converter (shift and add-3, one bit per cycle).
module dhf_bcd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dhf_pkg::MAG_W-1:0]   i_bin,
    output logic                        o_done,
    output logic [dhf_pkg::BCD_W-1:0]   o_bcd
);
    import dhf_pkg::*;

    localparam int SH_W  = BCD_W + MAG_W;
    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam int NDIG  = BCD_W / 4;

    logic [SH_W-1:0]  r_sh, n_sh;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [BCD_W-1:0] adj;

    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            adj[4*k +: 4] = (r_sh[MAG_W + 4*k +: 4] >= 4'd5) ?
                            r_sh[MAG_W + 4*k +: 4] + 4'd3 : r_sh[MAG_W + 4*k +: 4];
        end
        n_sh = {adj[BCD_W-2:0], r_sh[MAG_W-1:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_sh   <= {{BCD_W{1'b0}}, i_bin};
                r_cnt  <= CNT_W'(MAG_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_sh  <= n_sh;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_sh[SH_W-1 -: BCD_W];

endmodule

// File: test/tb_top.sv
// Self-checking testbench for double_to_hex_float_text_top: directed table, then random values.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_VALUES = 250;

    typedef struct {
        logic [dhf_pkg::CHAR_W-1:0] code;
        logic                       last;
    } t_text_char;

    typedef struct {
        logic [dhf_pkg::VALUE_W-1:0] bits;
        logic                        up;
        string                       text;
    } t_value_row;

    logic i_clk;
    logic i_rst_n;

    dhf_in_if  in_ch ();
    dhf_out_if out_ch ();

    double_to_hex_float_text_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_text_char text_due[$];
    t_value_row value_table[$];
    int         fails;
    int         chars_seen;
    int         quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic string render_hex_float(logic [63:0] bits, logic up);
        logic [10:0] ex_field;
        logic [52:0] man;
        int          shift;
        int          ex_val;
        int          keep;
        int          nib;
        string       txt;
        string       digs;
        string       p_letter;
        string       ex_sign;
        ex_field = bits[62:52];
        man      = {1'b0, bits[51:0]};
        txt      = bits[63] ? "-" : "";
        digs     = up ? "0123456789ABCDEF" : "0123456789abcdef";
        p_letter = up ? "P" : "p";
        if (ex_field == dhf_pkg::EXP_ALL_ONES) begin
            if (man != 0) begin
                return {txt, up ? "NAN" : "nan"};
            end
            return {txt, up ? "INF" : "inf"};
        end
        txt = {txt, up ? "0X" : "0x"};
        if (ex_field == 0 && man == 0) begin
            return {txt, "0", p_letter, "+0"};
        end
        if (ex_field == 0) begin
            shift = 0;
            while (!man[52]) begin
                man = man << 1;
                shift++;
            end
            ex_val = -int'(dhf_pkg::SUBN_BASE) - shift;
        end else begin
            ex_val = int'(ex_field) - int'(dhf_pkg::EXP_BIAS);
        end
        txt  = {txt, "1."};
        keep = 13;
        while (keep > 0 && man[52-4*keep +: 4] == 4'h0) keep--;
        if (keep == 0) begin
            txt = {txt, "0"};
        end
        for (int i = 0; i < keep; i++) begin
            nib = int'(man[48-4*i +: 4]);
            txt = {txt, digs.substr(nib, nib)};
        end
        ex_sign = (ex_val < 0) ? "-" : "+";
        return {txt, p_letter, ex_sign, $sformatf("%0d", (ex_val < 0) ? -ex_val : ex_val)};
    endfunction

    function automatic void expect_text(string text);
        t_text_char c;
        for (int i = 0; i < text.len(); i++) begin
            c.code = text[i];
            c.last = (i == text.len() - 1);
            text_due.insert(text_due.size(), c);
        end
    endfunction

    function automatic void add_row(logic [63:0] bits, logic up, string text);
        t_value_row r;
        r.bits = bits;
        r.up   = up;
        r.text = text;
        value_table.insert(value_table.size(), r);
    endfunction

    function automatic logic [63:0] draw_value();
        logic [63:0] v;
        logic [51:0] frac;
        int          w;
        int          k;
        v    = {$urandom, $urandom};
        frac = v[51:0];
        case ($urandom_range(0, 9))
            0: v = {v[63], 63'b0};
            1: v = {v[63], 11'h7FF, ($urandom_range(0, 1) == 0) ? 52'b0 : frac};
            2, 3: begin
                w    = $urandom_range(1, 52);
                frac = (frac & ~({52{1'b1}} << w)) | (52'b1 << (w - 1));
                v    = {v[63], 11'h000, frac};
            end
            4, 5: begin
                k = $urandom_range(0, 13);
                v = {v[63:52], frac & ({52{1'b1}} << (52 - 4 * k))};
            end
            6: begin
                case ($urandom_range(0, 5))
                    0: v[62:52] = 11'h001;
                    1: v[62:52] = 11'h002;
                    2: v[62:52] = 11'h7FE;
                    3: v[62:52] = 11'h7FD;
                    4: v[62:52] = 11'h3FF;
                    default: v[62:52] = 11'h3FE;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_value(logic [63:0] bits, logic up, string text, int idx);
        int gap;
        gap = ((idx / 40) % 3 == 2) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.value_bits = bits;
        in_ch.upper_case = up;
        do @(posedge i_clk); while (!in_ch.ready);
        expect_text(text);
        @(negedge i_clk);
    endtask

    initial begin
        string       text;
        logic [63:0] bits;
        logic        up;
        in_ch.valid      = 1'b0;
        in_ch.value_bits = '0;
        in_ch.upper_case = 1'b0;
        fails            = 0;
        i_rst_n          = 1'b0;
        add_row(64'h0000000000000000, 1'b0, "0x0p+0");
        add_row(64'h8000000000000000, 1'b1, "-0X0P+0");
        add_row(64'h7FF0000000000000, 1'b0, "inf");
        add_row(64'hFFF0000000000000, 1'b1, "-INF");
        add_row(64'h7FF8000000000000, 1'b0, "nan");
        add_row(64'hFFF0000000000001, 1'b1, "-NAN");
        add_row(64'hFFFFFFFFFFFFFFFF, 1'b0, "-nan");
        add_row(64'h3FF0000000000000, 1'b0, "0x1.0p+0");
        add_row(64'h7FEFFFFFFFFFFFFF, 1'b0, "0x1.fffffffffffffp+1023");
        add_row(64'hFFEFFFFFFFFFFFFF, 1'b1, "-0X1.FFFFFFFFFFFFFP+1023");
        add_row(64'h0010000000000000, 1'b0, "0x1.0p-1022");
        add_row(64'h0000000000000001, 1'b0, "0x1.0p-1074");
        add_row(64'h800FFFFFFFFFFFFF, 1'b1, "-0X1.FFFFFFFFFFFFEP-1023");
        add_row(64'h3FF0123456789ABC, 1'b0, "0x1.0123456789abcp+0");
        add_row(64'h3FFFEDCBA9876543, 1'b1, "0X1.FEDCBA9876543P+0");
        add_row(64'h4000000000000000, 1'b0, "0x1.0p+1");
        add_row(64'h3FE0000000000000, 1'b1, "0X1.0P-1");
        add_row(64'h0008000000000000, 1'b0, "");
        add_row(64'h400921FB54442D18, 1'b0, "");
        add_row(64'h3FF0000000000010, 1'b1, "");
        add_row(64'h0000000080000000, 1'b0, "");
        add_row(64'hC0C3880000000000, 1'b1, "");
        add_row(64'h800000000000000F, 1'b1, "");
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (value_table[i]) begin
            text = value_table[i].text;
            if (text == "") begin
                text = render_hex_float(value_table[i].bits, value_table[i].up);
            end
            send_value(value_table[i].bits, value_table[i].up, text, i);
        end
        for (int i = 0; i < RANDOM_VALUES; i++) begin
            bits = draw_value();
            up   = 1'($urandom_range(0, 1));
            send_value(bits, up, render_hex_float(bits, up), i);
        end
        in_ch.valid = 1'b0;
        while (text_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        t_text_char due;
        int         stall;
        out_ch.ready = 1'b0;
        chars_seen   = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = ((chars_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            chars_seen++;
            if (text_due.size() == 0) begin
                fails++;
                if (fails <= 10) begin
                    $display("unexpected character transfer: char %h last %b",
                             out_ch.char_code, out_ch.last_char);
                end
            end else begin
                due = text_due.pop_front();
                if (out_ch.char_code !== due.code || out_ch.last_char !== due.last) begin
                    fails++;
                    if (fails <= 10) begin
                        $display({"character mismatch: expected char %h last %b, ",
                                  "got char %h last %b"},
                                 due.code, due.last, out_ch.char_code, out_ch.last_char);
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// File: filelist.f
rtl/dhf_pkg.sv
rtl/dhf_if.sv
rtl/dhf_bcd.sv
rtl/double_to_hex_float_text_top.sv
test/tb_top.sv
